[hdl/tgnc_pkg.sv]
// Shared types, codes and constants of the toroidal grid neighbor counter.
`timescale 1ns / 1ps
`default_nettype none

package tgnc_pkg;

  // Field widths of the request and response channels.
  localparam int REQ_BITS    = 3;
  localparam int POS_BITS    = 6;
  localparam int LABEL_BITS  = 4;
  localparam int COUNT_BITS  = 4;

  // Configuration port.
  localparam int CFG_BITS       = 7;
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

  // Defaults of the top-level parameters.
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_KIND_BITS  = 4;

  // Label codes.
  localparam int unsigned LABEL_EMPTY    = 0;
  localparam int unsigned LABEL_OBSTACLE = 1;

  // Neighbor scan lengths.
  localparam int NB_ALL   = 8;
  localparam int NB_CROSS = 4;

  // Coordinate reduction retires two bits per cycle.
  localparam int RED_STEPS    = POS_BITS / 2;
  localparam int RED_CNT_BITS = $clog2(RED_STEPS);

  typedef enum logic [REQ_BITS-1:0] {
    OP_PLACE       = 3'd0,
    OP_REMOVE      = 3'd1,
    OP_READ        = 3'd2,
    OP_COUNT_OCC   = 3'd3,
    OP_COUNT_LABEL = 3'd4,
    OP_CLEAR_ALL   = 3'd5
  } req_type_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_WRITE,
    S_READ,
    S_COUNT,
    S_DRAIN,
    S_COL,
    S_ROW,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    D_ZERO,
    D_PLUS,
    D_MINUS
  } nb_off_t;

  // Neighbor offsets in scan order; the first four are the plain directions.
  localparam nb_off_t NB_DX [NB_ALL] = '{D_PLUS, D_MINUS, D_ZERO, D_ZERO,
                                         D_PLUS, D_MINUS, D_MINUS, D_PLUS};
  localparam nb_off_t NB_DY [NB_ALL] = '{D_ZERO, D_ZERO, D_PLUS, D_MINUS,
                                         D_PLUS, D_MINUS, D_PLUS, D_MINUS};

  typedef struct packed {
    logic [REQ_BITS-1:0]   req_type;
    logic [POS_BITS-1:0]   pos_x;
    logic [POS_BITS-1:0]   pos_y;
    logic [POS_BITS-1:0]   corner_x;
    logic [POS_BITS-1:0]   corner_y;
    logic                  draw_rectangle;
    logic [LABEL_BITS-1:0] cell_kind;
    logic                  use_diagonals;
    logic                  match_any;
  } req_data_t;

  typedef struct packed {
    logic [LABEL_BITS-1:0] read_kind;
    logic [COUNT_BITS-1:0] neighbor_total;
  } rsp_data_t;

  // A size of zero acts as one and a size above the limit acts as the limit.
  function automatic int unsigned clamp_dim(logic [CFG_BITS-1:0] v, int unsigned limit);
    int unsigned r;
    r = 32'(v);
    if (r == 0) begin
      r = 1;
    end else if (r > limit) begin
      r = limit;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/tgnc_req_if.sv]
// Request channel of the toroidal grid neighbor counter.
`timescale 1ns / 1ps
`default_nettype none

interface tgnc_req_if import tgnc_pkg::*; ();
  logic      valid;
  logic      ready;
  req_data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/tgnc_rsp_if.sv]
// Response channel of the toroidal grid neighbor counter.
`timescale 1ns / 1ps
`default_nettype none

interface tgnc_rsp_if import tgnc_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/toroidal_grid_neighbor_counter_unit.sv]
// Top level of the toroidal grid neighbor counter: cell memory and request sequencer.
// One request is in work at a time; the next is taken once the result sits in the output
// register. Speed is set by the single cell memory port and the 2-bit-per-cycle modulo.
// Synchronous reset; afterwards a clearing pass writes all 2^(XB+YB) cells (4096 by default).
`timescale 1ns / 1ps
`default_nettype none

// The grid lives in one synchronous memory of 2^(XB+YB) cells, addressed as
// {x, y}. Every request first reduces its coordinates modulo the configured
// width and height; this is a restoring remainder that handles two bits of
// each coordinate per cycle, four lanes in parallel (both corners).
//
// After that the sequencer does one of the following:
//   - a single write for place and remove,
//   - a single read for read, with the data taken in the next cycle,
//   - four or eight neighbor reads, one per cycle, with the match count
//     accumulated as the read data returns,
//   - an obstacle outline walk, two writes per row or column step,
//   - a sweep that writes zero to every cell for clear all.
// The same sweep runs after reset; no request is taken while it runs, but
// configuration writes are.
//
// Each finished result is placed in an output register, so the next request
// transfer can happen while the previous response still waits to be taken.
module toroidal_grid_neighbor_counter_unit
  import tgnc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int KIND_BITS  = DEF_KIND_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_data,
  tgnc_req_if.sink                       req,
  tgnc_rsp_if.source                     rsp
);

  localparam int XB    = $clog2(MAX_WIDTH);
  localparam int YB    = $clog2(MAX_HEIGHT);
  localparam int AB    = XB + YB;
  localparam int DEPTH = 1 << AB;
  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int HB    = $clog2(MAX_HEIGHT + 1);
  // Common width of coordinate arithmetic; one spare bit for the remainder shift.
  localparam int CB    = ((XB > YB) ? XB : YB) + 1;
  localparam int NB_IDX_BITS = $clog2(NB_ALL);

  // Remainder step: shift one coordinate bit in, subtract the size if reached.
  function automatic logic [CB-1:0] rem_step(logic [CB-1:0] r, logic b, logic [CB-1:0] d);
    logic [CB-1:0] t;
    t = {r[CB-2:0], b};
    if (t >= d) begin
      t = t - d;
    end
    return t;
  endfunction

  function automatic logic [CB-1:0] wrap_inc(logic [CB-1:0] v, logic [CB-1:0] d);
    logic [CB-1:0] s;
    s = v + 1'b1;
    return (s == d) ? '0 : s;
  endfunction

  function automatic logic [CB-1:0] wrap_dec(logic [CB-1:0] v, logic [CB-1:0] d);
    return (v == '0) ? (d - 1'b1) : (v - 1'b1);
  endfunction

  // Effective sizes, clamped when written.
  logic [WB-1:0] eff_w;
  logic [HB-1:0] eff_h;
  logic [CB-1:0] ew, eh;

  // Sequencer.
  state_t state, state_next;
  logic   clr_req;
  logic [AB-1:0] clr_cnt;

  // Saved request.
  req_type_t             op;
  logic [POS_BITS-1:0]   pos_x, pos_y, corner_x, corner_y;
  logic                  rect;
  logic [KIND_BITS-1:0]  kind;
  logic                  diag;
  logic                  any_sel;

  // Coordinate reduction lanes.
  logic [POS_BITS-1:0]     sx1, sy1, sx2, sy2;
  logic [CB-1:0]           rx1, ry1, rx2, ry2;
  logic [CB-1:0]           rx1_next, ry1_next, rx2_next, ry2_next;
  logic [RED_CNT_BITS-1:0] red_cnt;
  logic                    red_last;

  // Neighbor scan and outline walk.
  logic [NB_IDX_BITS-1:0] nb_idx, nb_last;
  logic [CB-1:0]          nb_x, nb_y;
  logic [CB-1:0]          wx, wy;
  logic [POS_BITS-1:0]    walk_raw, row_end;
  logic                   half;
  logic                   col_start, row_start;

  // Memory.
  logic [KIND_BITS-1:0] cells [DEPTH];
  logic [KIND_BITS-1:0] rd_data;
  logic [AB-1:0]        mem_addr;
  logic                 mem_we;
  logic [KIND_BITS-1:0] mem_wdata;

  // Results.
  logic                  take;
  logic                  any_mode, hit;
  logic [KIND_BITS-1:0]  res_kind;
  logic [COUNT_BITS-1:0] res_total;
  logic                  out_valid;
  logic [LABEL_BITS-1:0] out_kind;
  logic [COUNT_BITS-1:0] out_total;
  logic                  out_load;
  logic                  req_fire;

  assign ew = CB'(eff_w);
  assign eh = CB'(eff_h);

  assign req_fire = req.valid && req.ready;

  assign rsp.valid = out_valid;
  assign rsp.data  = '{read_kind: out_kind, neighbor_total: out_total};

  // Two remainder steps per cycle, MSB first.
  always_comb begin
    rx1_next = rem_step(rem_step(rx1, sx1[POS_BITS-1], ew), sx1[POS_BITS-2], ew);
    ry1_next = rem_step(rem_step(ry1, sy1[POS_BITS-1], eh), sy1[POS_BITS-2], eh);
    rx2_next = rem_step(rem_step(rx2, sx2[POS_BITS-1], ew), sx2[POS_BITS-2], ew);
    ry2_next = rem_step(rem_step(ry2, sy2[POS_BITS-1], eh), sy2[POS_BITS-2], eh);
  end

  assign red_last  = (red_cnt == RED_CNT_BITS'(RED_STEPS - 1));
  assign col_start = (pos_y <= corner_y);
  assign row_start = (({1'b0, pos_x} + 1'b1) < {1'b0, corner_x});
  assign row_end   = corner_x - 1'b1;
  assign nb_last   = (op == OP_COUNT_OCC && !diag) ? NB_IDX_BITS'(NB_CROSS - 1)
                                                   : NB_IDX_BITS'(NB_ALL - 1);

  // Neighbor coordinates for the current scan index.
  always_comb begin
    unique case (NB_DX[nb_idx])
      D_PLUS:  nb_x = wrap_inc(rx1, ew);
      D_MINUS: nb_x = wrap_dec(rx1, ew);
      default: nb_x = rx1;
    endcase
    unique case (NB_DY[nb_idx])
      D_PLUS:  nb_y = wrap_inc(ry1, eh);
      D_MINUS: nb_y = wrap_dec(ry1, eh);
      default: nb_y = ry1;
    endcase
  end

  // Match test on returning read data.
  assign any_mode = (op == OP_COUNT_OCC) || any_sel;
  assign hit = (rd_data != KIND_BITS'(LABEL_EMPTY)) &&
               (any_mode ? (rd_data != KIND_BITS'(LABEL_OBSTACLE)) : (rd_data == kind));

  // Next state and memory controls.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_wdata  = '0;
    mem_addr   = {XB'(rx1), YB'(ry1)};
    req.ready  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
        if (clr_cnt == '1) begin
          state_next = clr_req ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          unique case (req_type_t'(req.data.req_type))
            OP_CLEAR_ALL: state_next = S_CLEAR;
            OP_PLACE, OP_REMOVE, OP_READ, OP_COUNT_OCC, OP_COUNT_LABEL: state_next = S_REDUCE;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_REDUCE: begin
        if (red_last) begin
          unique case (op)
            OP_PLACE: begin
              if (!rect) begin
                state_next = S_WRITE;
              end else if (col_start) begin
                state_next = S_COL;
              end else if (row_start) begin
                state_next = S_ROW;
              end else begin
                state_next = S_DONE;
              end
            end
            OP_REMOVE: state_next = S_WRITE;
            OP_READ: state_next = S_READ;
            OP_COUNT_OCC, OP_COUNT_LABEL: state_next = S_COUNT;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_WRITE: begin
        mem_we     = 1'b1;
        mem_wdata  = (op == OP_PLACE) ? kind : KIND_BITS'(LABEL_EMPTY);
        state_next = S_DONE;
      end
      S_READ: begin
        state_next = S_DRAIN;
      end
      S_COUNT: begin
        mem_addr = {XB'(nb_x), YB'(nb_y)};
        if (nb_idx == nb_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_COL: begin
        mem_we    = 1'b1;
        mem_wdata = KIND_BITS'(LABEL_OBSTACLE);
        mem_addr  = half ? {XB'(rx2), YB'(wy)} : {XB'(rx1), YB'(wy)};
        if (half && walk_raw == corner_y) begin
          state_next = row_start ? S_ROW : S_DONE;
        end
      end
      S_ROW: begin
        mem_we    = 1'b1;
        mem_wdata = KIND_BITS'(LABEL_OBSTACLE);
        mem_addr  = half ? {XB'(wx), YB'(ry2)} : {XB'(wx), YB'(ry1)};
        if (half && walk_raw == row_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Cell memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_addr] <= mem_wdata;
    end
    rd_data <= cells[mem_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      clr_req   <= 1'b0;
      take      <= 1'b0;
      out_valid <= 1'b0;
      eff_w     <= WB'(clamp_dim(CFG_RESET, MAX_WIDTH));
      eff_h     <= HB'(clamp_dim(CFG_RESET, MAX_HEIGHT));
    end else begin
      state   <= state_next;
      clr_cnt <= (state == S_CLEAR) ? clr_cnt + 1'b1 : '0;
      take    <= (state == S_READ) || (state == S_COUNT);
      if (req_fire) begin
        clr_req <= (req_type_t'(req.data.req_type) == OP_CLEAR_ALL);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_GRID_WIDTH:  eff_w <= WB'(clamp_dim(cfg_data, MAX_WIDTH));
          REG_GRID_HEIGHT: eff_h <= HB'(clamp_dim(cfg_data, MAX_HEIGHT));
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      op        <= req_type_t'(req.data.req_type);
      pos_x     <= req.data.pos_x;
      pos_y     <= req.data.pos_y;
      corner_x  <= req.data.corner_x;
      corner_y  <= req.data.corner_y;
      rect      <= req.data.draw_rectangle;
      kind      <= KIND_BITS'(req.data.cell_kind);
      diag      <= req.data.use_diagonals;
      any_sel   <= req.data.match_any;
      sx1       <= req.data.pos_x;
      sy1       <= req.data.pos_y;
      sx2       <= req.data.corner_x;
      sy2       <= req.data.corner_y;
      rx1       <= '0;
      ry1       <= '0;
      rx2       <= '0;
      ry2       <= '0;
      red_cnt   <= '0;
      nb_idx    <= '0;
      res_kind  <= '0;
      res_total <= '0;
    end

    if (state == S_REDUCE) begin
      rx1     <= rx1_next;
      ry1     <= ry1_next;
      rx2     <= rx2_next;
      ry2     <= ry2_next;
      sx1     <= sx1 << 2;
      sy1     <= sy1 << 2;
      sx2     <= sx2 << 2;
      sy2     <= sy2 << 2;
      red_cnt <= red_cnt + 1'b1;
      if (red_last) begin
        // Set up the outline walk from the final reduced corners.
        half     <= 1'b0;
        wy       <= ry1_next;
        wx       <= wrap_inc(rx1_next, ew);
        walk_raw <= col_start ? pos_y : (pos_x + 1'b1);
      end
    end

    if (state == S_COUNT) begin
      nb_idx <= nb_idx + 1'b1;
    end

    if (state == S_COL) begin
      half <= ~half;
      if (half) begin
        wy <= wrap_inc(wy, eh);
        walk_raw <= (walk_raw == corner_y) ? (pos_x + 1'b1) : (walk_raw + 1'b1);
      end
    end

    if (state == S_ROW) begin
      half <= ~half;
      if (half) begin
        wx       <= wrap_inc(wx, ew);
        walk_raw <= walk_raw + 1'b1;
      end
    end

    if (take) begin
      if (op == OP_READ) begin
        res_kind <= rd_data;
      end else if (hit) begin
        res_total <= res_total + 1'b1;
      end
    end

    if (out_load) begin
      out_kind  <= LABEL_BITS'(res_kind);
      out_total <= res_total;
    end
  end

  // Reduced target coordinates stay inside the configured grid.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE || state == S_READ || state == S_COUNT) |->
      (rx1 < ew && ry1 < eh))
    else $error("reduced coordinate outside the grid");

  // The outline walk never leaves the configured grid.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_COL |-> wy < eh) and (state == S_ROW |-> (wx < ew && ry2 < eh)))
    else $error("outline walk outside the grid");

  // The neighbor scan stops at the last direction of its kind.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_COUNT) |-> (nb_idx <= nb_last))
    else $error("neighbor scan ran past its last direction");

  // A response appears only out of the result state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("response raised outside the result state");

endmodule

`default_nettype wire
